// File: src/pxd_pkg.sv
// Shared types, constants and helper functions for the password XOR byte decryptor.
package pxd_pkg;

  localparam int MAX_PASSWORD_CHARS = 16;
  localparam int POSITION_BITS      = 32;
  localparam int CHAR_W             = 8;
  localparam int CHAR_IDX_W         = (MAX_PASSWORD_CHARS > 1) ? $clog2(MAX_PASSWORD_CHARS) : 1;
  localparam int LEN_W              = 5;
  localparam int REM_W              = CHAR_IDX_W;
  localparam int CFG_DATA_W         = 64;
  localparam int CFG_IDX_W          = 3;
  localparam int PW_BITS            = 2 * CFG_DATA_W;
  localparam int CHK_W              = 16;
  localparam int CNT_W              = $clog2(POSITION_BITS);
  localparam int STEP_W             = 2;

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_DELTA   = 8'h20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PW_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PW_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PW_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd3;

  // Microprogram step addresses.
  localparam logic [STEP_W-1:0] STEP_IDLE = 2'd0;
  localparam logic [STEP_W-1:0] STEP_DIV  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_EMIT = 2'd2;

  typedef struct packed {
    logic [CHAR_W-1:0]        cipher_byte;
    logic [POSITION_BITS-1:0] file_position;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] plain_byte;
    logic              was_decrypted;
    logic [CHK_W-1:0]  password_checksum;
  } out_item_t;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_IN_VALID,
    JMP_CNT_LAST,
    JMP_OUT_FREE
  } jcond_t;

  // One microinstruction.
  typedef struct packed {
    logic              take_in;
    logic              div_step;
    logic              emit;
    jcond_t            cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Condition flags fed back from the datapath.
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } seq_status_t;

  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{take_in: 1'b0, div_step: 1'b0, emit: 1'b0, cond: JMP_NEVER, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: w = '{take_in: 1'b1, div_step: 1'b0, emit: 1'b0,
                       cond: JMP_IN_VALID, target: STEP_DIV};
      STEP_DIV:  w = '{take_in: 1'b0, div_step: 1'b1, emit: 1'b0,
                       cond: JMP_CNT_LAST, target: STEP_EMIT};
      STEP_EMIT: w = '{take_in: 1'b0, div_step: 1'b0, emit: 1'b1,
                       cond: JMP_OUT_FREE, target: STEP_IDLE};
      default:   w = '{take_in: 1'b0, div_step: 1'b0, emit: 1'b0,
                       cond: JMP_NEVER, target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Saturate the raw length register to the character capacity.
  function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] cap;
    cap = LEN_W'(MAX_PASSWORD_CHARS);
    return (raw > cap) ? cap : raw;
  endfunction

  // Pick one password character and upper-case a to z.
  function automatic logic [CHAR_W-1:0] upper_char(input logic [PW_BITS-1:0] pw,
                                                   input logic [CHAR_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = pw[idx*CHAR_W +: CHAR_W];
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      c = c - CASE_DELTA;
    end
    return c;
  endfunction

endpackage

// File: src/password_xor_byte_decryptor_core.sv
// Top level of the password XOR byte decryptor: config registers, datapath, output register.
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_ready     in_data   (cipher_byte, file_position)
//  out       output     out_valid / out_ready   out_data  (plain_byte, was_decrypted,
//                                                          password_checksum)
//  cfg       input      cfg_wr_en (no wait)     cfg_index, cfg_data
//
// Each transaction loads on the idle step, runs the restoring remainder unit over every
// position bit for (position - start) mod length, then emits on the emit step.
// The checksum fold over up to 16 characters runs alongside the remainder iterations.
// in_ready is high only on the idle step; the output register lets the next
// transaction enter while a finished result waits for out_ready.
// rst is synchronous, active high; it clears the config registers, the step counter
// and out_valid. The emit step holds until the output register is free.
module password_xor_byte_decryptor_core
  import pxd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [CFG_DATA_W-1:0]    pw_low;
  logic [CFG_DATA_W-1:0]    pw_high;
  logic [LEN_W-1:0]         pw_len;
  logic [POSITION_BITS-1:0] start_offset;

  // Per-transaction working registers.
  logic [CHAR_W-1:0]        byte_q;
  logic [CHAR_W-1:0]        mask_q;
  logic                     applied_q;
  logic [LEN_W-1:0]         len_q;
  logic [POSITION_BITS-1:0] dividend;
  logic [REM_W-1:0]         rem_q;
  logic [CHK_W-1:0]         chk_q;

  ctrl_word_t               ctrl;
  seq_status_t              status;
  logic [CNT_W-1:0]         cnt;

  logic [PW_BITS-1:0]       pw_all;
  logic [LEN_W-1:0]         len_used;
  logic                     in_acc;
  logic                     out_free;
  logic [REM_W:0]           rem_shift;
  logic [REM_W:0]           rem_sub;
  logic [CHAR_W-1:0]        key_char;
  logic [CHAR_W-1:0]        fold_char;
  out_item_t                result;

  assign pw_all   = {pw_high, pw_low};
  assign len_used = used_length(pw_len);
  assign in_ready = ctrl.take_in;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign status.in_valid = in_valid;
  assign status.out_free = out_free;

  pxd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .cnt    (cnt)
  );

  // Config writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pw_low       <= '0;
      pw_high      <= '0;
      pw_len       <= '0;
      start_offset <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PW_LOW:  pw_low       <= cfg_data;
        REG_PW_HIGH: pw_high      <= cfg_data;
        REG_PW_LEN:  pw_len       <= cfg_data[LEN_W-1:0];
        REG_START:   start_offset <= cfg_data[POSITION_BITS-1:0];
        default:     ;
      endcase
    end
  end

  // One restoring-remainder iteration: shift in the next dividend bit, subtract if it fits.
  assign rem_shift = {rem_q, dividend[POSITION_BITS-1]};
  assign rem_sub   = rem_shift - (REM_W+1)'(len_q);
  assign fold_char = upper_char(pw_all, cnt[CHAR_IDX_W-1:0]);
  assign key_char  = upper_char(pw_all, rem_q);

  always_ff @(posedge clk) begin
    if (ctrl.take_in && in_acc) begin
      // Latch the byte and set up the remainder and checksum loops.
      byte_q    <= in_data.cipher_byte;
      len_q     <= len_used;
      applied_q <= (len_used != '0) && (in_data.file_position >= start_offset);
      dividend  <= in_data.file_position - start_offset;
      mask_q    <= CHAR_W'(len_used) + 8'd1
                   + in_data.file_position[CHAR_W-1:0] - start_offset[CHAR_W-1:0];
      rem_q     <= '0;
      chk_q     <= '0;
    end else if (ctrl.div_step) begin
      dividend <= {dividend[POSITION_BITS-2:0], 1'b0};
      rem_q    <= (rem_shift >= (REM_W+1)'(len_q)) ? rem_sub[REM_W-1:0]
                                                   : rem_shift[REM_W-1:0];
      // Fold one character per iteration while inside the used length.
      if ((REM_W+1)'(cnt) < (REM_W+1)'(len_q) && cnt < CNT_W'(MAX_PASSWORD_CHARS)) begin
        chk_q <= {chk_q[0], chk_q[CHK_W-1:1]} ^ {fold_char, 8'h00};
      end
    end
  end

  always_comb begin
    result.plain_byte        = applied_q ? (byte_q ^ key_char ^ mask_q) : byte_q;
    result.was_decrypted     = applied_q;
    result.password_checksum = chk_q;
  end

  // Output register: load on the emit step when free, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      out_data <= result;
    end
  end

endmodule

// File: src/pxd_seq.sv
// Microprogram sequencer: step counter, control ROM and loop counter.
module pxd_seq
  import pxd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  seq_status_t      status,
  output ctrl_word_t       ctrl,
  output logic [CNT_W-1:0] cnt
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [CNT_W-1:0]  cnt_next;
  logic              cnt_last;
  logic              jump;

  assign ctrl     = ucode_rom(step);
  assign cnt_last = (cnt == CNT_W'(POSITION_BITS - 1));

  always_comb begin
    unique case (ctrl.cond)
      JMP_IN_VALID: jump = status.in_valid;
      JMP_CNT_LAST: jump = cnt_last;
      JMP_OUT_FREE: jump = status.out_free;
      default:      jump = 1'b0;
    endcase
    step_next = jump ? ctrl.target : step;
  end

  // Count division iterations; clear whenever the loop is not running.
  always_comb begin
    cnt_next = ctrl.div_step ? (cnt + 1'b1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
      cnt  <= '0;
    end else begin
      step <= step_next;
      cnt  <= cnt_next;
    end
  end

endmodule

// File: src/pxd_checker.sv
// Port-level assertions for the decryptor core, bound to the top level.
module pxd_checker
  import pxd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A held result stays valid until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transaction completed");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // After a transaction is taken, in_ready is checked low at the start of the remainder loop.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("in_ready returned too early after an accepted transaction");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // A valid result never carries an unknown decrypted flag.
  a_flag_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_data.was_decrypted))
    else $error("was_decrypted unknown on a valid result");

endmodule

bind password_xor_byte_decryptor_core pxd_checker u_pxd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
